// File: rtl/core/ambient_light_lux_classifier_macros.svh
// assertion macros shared by the lux classifier rtl
`ifndef AMBIENT_LIGHT_LUX_CLASSIFIER_MACROS_SVH
`define AMBIENT_LIGHT_LUX_CLASSIFIER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define ALLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define ALLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/allc_pkg.sv
// types, constants and helper functions of the lux classifier
`timescale 1ns / 1ps

package allc_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 20;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int CNT_W   = 16;
    localparam int LUX_W   = 24;
    localparam int LEVEL_W = 3;
    localparam int GAIN_W  = 16;
    localparam int RAW_W   = 36;
    localparam int NUM_LIMITS = 7;

    localparam logic [LUX_W-1:0] LUX_MAX = 24'hFFFFFF;

    // ratio branch edges in Q2.14
    localparam logic [CNT_W-1:0] EDGE_050 = 16'd8192;
    localparam logic [CNT_W-1:0] EDGE_061 = 16'd9994;
    localparam logic [CNT_W-1:0] EDGE_080 = 16'd13107;
    localparam logic [CNT_W-1:0] EDGE_130 = 16'd21299;

    // register indexes
    localparam logic [2:0] REG_GAIN        = 3'd0;
    localparam logic [2:0] REG_LIMIT_FIRST = 3'd1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
    localparam logic [LUX_W-1:0] LIMIT_RESET [NUM_LIMITS] = '{
        24'd256, 24'd2560, 24'd12800, 24'd51200, 24'd128000, 24'd512000, 24'd2560000
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_BR,
        S_PWMUL,
        S_RD0,
        S_RD1,
        S_INTERP,
        S_VP,
        S_B0,
        S_MB,
        S_MA,
        S_SUB,
        S_GAIN,
        S_SAT,
        S_CLS,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        BR_LOW,
        BR_MID,
        BR_HIGH,
        BR_TOP
    } t_branch;

    // Q0.24 coefficient on the visible+ir count
    function automatic logic [MUL_B_W-1:0] coef_a(input t_branch br);
        logic [MUL_B_W-1:0] c;
        unique case (br)
            BR_LOW:  c = 20'd510027;
            BR_MID:  c = 20'd375810;
            BR_HIGH: c = 20'd214748;
            BR_TOP:  c = 20'd24495;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Q0.24 coefficient on the ir term
    function automatic logic [MUL_B_W-1:0] coef_b(input t_branch br);
        logic [MUL_B_W-1:0] c;
        unique case (br)
            BR_LOW:  c = 20'd1040187;
            BR_MID:  c = 20'd520094;
            BR_HIGH: c = 20'd256691;
            BR_TOP:  c = 20'd18790;
            default: c = '0;
        endcase
        return c;
    endfunction

    // largest y with y^5 * den^7 <= 65536^5 * k^7, i.e. floor(65536*(k/den)^1.4)
    function automatic logic [15:0] pow_knot(input int unsigned k, input int unsigned den);
        logic [191:0] rhs;
        logic [191:0] lhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        rhs = 192'd1 << 80;
        for (int j = 0; j < 7; j++) begin
            rhs = rhs * 192'(k);
        end
        lo  = 0;
        hi  = 65535;
        mid = 0;
        for (int it = 0; it < 17; it++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                lhs = 192'd1;
                for (int j = 0; j < 5; j++) begin
                    lhs = lhs * 192'(mid);
                end
                for (int j = 0; j < 7; j++) begin
                    lhs = lhs * 192'(den);
                end
                if (lhs <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
        end
        return 16'(lo);
    endfunction

endpackage

// File: rtl/core/ambient_light_lux_classifier.sv
// top level of the two-channel lux classifier
//
//  port group   dir   word                                         handshake
//  s_axis_*     in    tdata: visible_ir_count, ir_count            tvalid/tready
//                     tuser: sample_valid
//  m_axis_*     out   tdata: lux_value, light_level; tuser: refreshed  tvalid/tready
//  apb          in    gain and seven level limits at 4*index       psel/penable/pready
//
// one word at a time: s_axis_tready is high only while the sequencer is idle
// invalid or all-zero words go straight to the result, ratio >= 4 or zero visible via the classify step
// divided words run the bit-serial ratio divider, then the branch pick and, for ratios
// below 1.30, passes through the one shared multiplier
// the result register lets the next word in while m_axis waits on tready
// reset is synchronous: gain and limits reload defaults, held result clears
`timescale 1ns / 1ps
`include "ambient_light_lux_classifier_macros.svh"

module ambient_light_lux_classifier
    import allc_pkg::*;
#(
    parameter int POWER_TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] visible_ir_count, [31:16] ir_count
    input  logic        s_axis_tuser,   // [0] sample_valid
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [23:0] lux_value, [26:24] light_level
    output logic        m_axis_tuser,   // [0] refreshed
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(POWER_TABLE_ENTRIES);
    localparam int DEN   = 2 * (POWER_TABLE_ENTRIES - 1);
    localparam logic [MUL_B_W-1:0] KNOT_SPAN = MUL_B_W'(POWER_TABLE_ENTRIES - 1);

    // ---------------------------------------------------------------- config
    logic [GAIN_W-1:0] r_gain;
    logic [LUX_W-1:0]  r_limit [NUM_LIMITS];
    logic              w_cfg_wr;
    logic [2:0]        w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RESET;
            r_limit <= LIMIT_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_GAIN: r_gain <= pwdata[GAIN_W-1:0];
                default:  r_limit[3'(w_cfg_idx - REG_LIMIT_FIRST)] <= pwdata[LUX_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_GAIN: prdata = 32'(r_gain);
            default:  prdata = 32'(r_limit[3'(w_cfg_idx - REG_LIMIT_FIRST)]);
        endcase
    end

    // ---------------------------------------------------------------- power table
    logic [15:0] w_pow_tab [POWER_TABLE_ENTRIES];

    for (genvar g = 0; g < POWER_TABLE_ENTRIES; g++) begin : g_knot
        assign w_pow_tab[g] = pow_knot(g, DEN);
    end

    // ---------------------------------------------------------------- datapath
    t_state             r_state, n_state;
    t_branch            r_br;
    logic [CNT_W-1:0]   r_vis, r_ir;
    logic [CNT_W:0]     r_rem;
    logic [CNT_W-1:0]   r_dvd, r_quo;
    logic [3:0]         r_cnt;
    logic [IDX_W-1:0]   r_idx;
    logic [12:0]        r_f;
    logic [15:0]        r_rom, r_t0;
    logic [RAW_W-1:0]   r_acc, r_raw;
    logic [LUX_W-1:0]   r_lux_new;
    logic [LUX_W-1:0]   r_held_lux;
    logic [LEVEL_W-1:0] r_held_level;
    logic               r_fresh;
    logic               r_m_valid;
    logic [LUX_W-1:0]   r_m_lux;
    logic [LEVEL_W-1:0] r_m_level;
    logic               r_m_fresh;

    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [MUL_P_W-1:0] w_prod;
    logic [IDX_W-1:0]   w_rom_addr;
    logic [CNT_W:0]     w_trial;
    logic               w_take;
    logic [15:0]        w_pw;
    logic [LEVEL_W-1:0] w_level;
    logic               w_in_acc;
    logic               w_out_load;
    logic               w_s_valid;
    logic [CNT_W-1:0]   w_s_vis, w_s_ir;

    assign w_s_valid = s_axis_tuser;
    assign w_s_vis   = s_axis_tdata[15:0];
    assign w_s_ir    = s_axis_tdata[31:16];

    allc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // restoring divider step: one quotient bit of ir*2^14 / vis per cycle
    assign w_trial = {r_rem[CNT_W-1:0], r_dvd[CNT_W-1]};
    assign w_take  = w_trial >= {1'b0, r_vis};

    // interpolated power, built from the registered knot and product
    assign w_pw = 16'(r_t0 + w_prod[28:13]);

    assign w_rom_addr = (r_state == S_RD0) ? w_prod[13 +: IDX_W] : IDX_W'(r_idx + 1'b1);

    always_ff @(posedge i_clk) begin
        r_rom <= w_pow_tab[w_rom_addr];
    end

    // first limit that the new lux is below sets the level
    always_comb begin
        w_level = LEVEL_W'(NUM_LIMITS);
        for (int k = NUM_LIMITS - 1; k >= 0; k--) begin
            if (r_lux_new < r_limit[k]) begin
                w_level = LEVEL_W'(k);
            end
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_in_acc      = 1'b0;
        w_out_load    = 1'b0;
        w_mul_a       = '0;
        w_mul_b       = '0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                w_in_acc      = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    if (!w_s_valid || (w_s_vis == '0 && w_s_ir == '0)) begin
                        n_state = S_DONE;
                    end else if (w_s_vis == '0 || {2'b00, w_s_ir} >= {w_s_vis, 2'b00}) begin
                        n_state = S_CLS;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_BR;
                end
            end
            S_BR: begin
                if (r_quo < EDGE_050) begin
                    n_state = S_PWMUL;
                end else if (r_quo < EDGE_130) begin
                    n_state = S_MB;
                end else begin
                    n_state = S_CLS;
                end
            end
            S_PWMUL: begin
                w_mul_a = MUL_A_W'(r_quo[12:0]);
                w_mul_b = KNOT_SPAN;
                n_state = S_RD0;
            end
            S_RD0: n_state = S_RD1;
            S_RD1: n_state = S_INTERP;
            S_INTERP: begin
                w_mul_a = MUL_A_W'(16'(r_rom - r_t0));
                w_mul_b = MUL_B_W'(r_f);
                n_state = S_VP;
            end
            S_VP: begin
                w_mul_a = MUL_A_W'(w_pw);
                w_mul_b = MUL_B_W'(r_vis);
                n_state = S_B0;
            end
            S_B0: begin
                w_mul_a = MUL_A_W'(w_prod[31:0]);
                w_mul_b = coef_b(BR_LOW);
                n_state = S_MA;
            end
            S_MB: begin
                w_mul_a = MUL_A_W'(r_ir);
                w_mul_b = coef_b(r_br);
                n_state = S_MA;
            end
            S_MA: begin
                w_mul_a = MUL_A_W'(r_vis);
                w_mul_b = coef_a(r_br);
                n_state = S_SUB;
            end
            S_SUB: n_state = S_GAIN;
            S_GAIN: begin
                w_mul_a = r_raw;
                w_mul_b = MUL_B_W'(r_gain);
                n_state = S_SAT;
            end
            S_SAT: n_state = S_CLS;
            S_CLS: n_state = S_DONE;
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_vis     <= w_s_vis;
                r_ir      <= w_s_ir;
                r_rem     <= {3'b000, w_s_ir[15:2]};
                r_dvd     <= {w_s_ir[1:0], 14'd0};
                r_quo     <= '0;
                r_cnt     <= 4'd15;
                r_lux_new <= '0;
            end
            S_DIV: begin
                r_rem <= w_take ? (w_trial - {1'b0, r_vis}) : w_trial;
                r_dvd <= {r_dvd[CNT_W-2:0], 1'b0};
                r_quo <= {r_quo[CNT_W-2:0], w_take};
                r_cnt <= r_cnt - 1'b1;
            end
            S_BR: begin
                if (r_quo < EDGE_050) begin
                    r_br <= BR_LOW;
                end else if (r_quo < EDGE_061) begin
                    r_br <= BR_MID;
                end else if (r_quo < EDGE_080) begin
                    r_br <= BR_HIGH;
                end else begin
                    r_br <= BR_TOP;
                end
            end
            S_RD0: begin
                r_idx <= w_prod[13 +: IDX_W];
                r_f   <= w_prod[12:0];
            end
            S_RD1: r_t0 <= r_rom;
            S_MA: begin
                // ir term: low branch carries the extra >>16 of the power product
                if (r_br == BR_LOW) begin
                    r_acc <= w_prod[16 +: RAW_W];
                end else begin
                    r_acc <= w_prod[RAW_W-1:0];
                end
            end
            S_SUB: begin
                if (w_prod[RAW_W-1:0] >= r_acc) begin
                    r_raw <= w_prod[RAW_W-1:0] - r_acc;
                end else begin
                    r_raw <= '0;
                end
            end
            S_SAT: begin
                if (|w_prod[MUL_P_W-1:28+LUX_W]) begin
                    r_lux_new <= LUX_MAX;
                end else begin
                    r_lux_new <= w_prod[28 +: LUX_W];
                end
            end
            default: ;
        endcase
    end

    // held result and its refresh flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_lux   <= '0;
            r_held_level <= '0;
            r_fresh      <= 1'b0;
        end else if (w_in_acc) begin
            r_fresh <= 1'b0;
        end else if (r_state == S_CLS) begin
            r_held_lux   <= r_lux_new;
            r_held_level <= w_level;
            r_fresh      <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_lux   <= r_held_lux;
            r_m_level <= r_held_level;
            r_m_fresh <= r_fresh;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'd0, r_m_level, r_m_lux};
    assign m_axis_tuser  = r_m_fresh;

    // ---------------------------------------------------------------- checks
    `ALLC_ASSERT_NEXT(a_skip_invalid, w_in_acc && !w_s_valid, r_state == S_DONE && !r_fresh, "invalid word was not passed straight to the result")
    `ALLC_ASSERT_NOW(a_div_exact, r_state == S_BR, (32'(r_quo) * 32'(r_vis) <= 32'({r_ir, 14'd0})) && (r_rem < {1'b0, r_vis}), "ratio divider result out of bounds")
    `ALLC_ASSERT_NOW(a_dark_zero, r_state == S_CLS && r_vis == '0, r_lux_new == '0, "zero visible count gave nonzero lux")
    `ALLC_ASSERT_NEXT(a_out_held, w_out_load, r_m_lux == r_held_lux && r_m_level == r_held_level, "result word differs from held result")

endmodule

// File: rtl/core/allc_mul.sv
// shared registered multiplier of the lux datapath
`timescale 1ns / 1ps

module allc_mul
    import allc_pkg::*;
(
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_prod
);

    logic [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule
